// ===== rtl/lattice_gas_rotate_and_stream_top_macros.svh =====
// Assertion macros for the lattice gas rotate-and-stream block.
// Used by the checker that is bound to the top level; depends on nothing.
`ifndef LATTICE_GAS_ROTATE_AND_STREAM_TOP_MACROS_SVH
`define LATTICE_GAS_ROTATE_AND_STREAM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define LGRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define LGRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lgrs_pkg.sv =====
// Package for the lattice gas rotate-and-stream block: grid geometry, field widths,
// command and register codes, state encoding and coordinate wrap tables. No dependencies.
`default_nettype none

package lgrs_pkg;

    // Grid geometry.
    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;
    localparam int X_W         = $clog2(GRID_WIDTH);
    localparam int Y_W         = $clog2(GRID_HEIGHT);
    localparam int ADDR_W      = X_W + Y_W;
    localparam int CELL_COUNT  = 1 << ADDR_W;

    // Field widths.
    localparam int CMD_W       = 2;
    localparam int COORD_W     = 8;
    localparam int BITS_W      = 4;
    localparam int DRAW_W      = 16;
    localparam int THR_W       = 17;
    localparam int ROT_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int COORD_COUNT = 1 << COORD_W;

    // Threshold values after reset.
    localparam logic [THR_W-1:0] STAY_RESET    = THR_W'(16384);
    localparam logic [THR_W-1:0] QUARTER_RESET = THR_W'(32768);
    localparam logic [THR_W-1:0] HALF_RESET    = THR_W'(49152);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COLLIDE = 2'd1,
        CMD_COMMIT  = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STAY    = 2'd0,
        CFG_QUARTER = 2'd1,
        CFG_HALF    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Coordinate reduction tables: an incoming coordinate taken modulo the grid size.
    typedef logic [X_W-1:0] x_wrap_t [COORD_COUNT];
    typedef logic [Y_W-1:0] y_wrap_t [COORD_COUNT];

    function automatic x_wrap_t build_x_wrap();
        x_wrap_t t;
        for (int i = 0; i < COORD_COUNT; i++)
        begin
            t[i] = X_W'(i % GRID_WIDTH);
        end
        return t;
    endfunction

    function automatic y_wrap_t build_y_wrap();
        y_wrap_t t;
        for (int i = 0; i < COORD_COUNT; i++)
        begin
            t[i] = Y_W'(i % GRID_HEIGHT);
        end
        return t;
    endfunction

    localparam x_wrap_t X_WRAP = build_x_wrap();
    localparam y_wrap_t Y_WRAP = build_y_wrap();

endpackage

`default_nettype wire

// ===== rtl/lgrs_channels_if.sv =====
// Valid/ready channel interfaces for the lattice gas block: command items,
// result items and configuration writes. Depends on lgrs_pkg.
`default_nettype none

interface lgrs_in_if import lgrs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic [BITS_W-1:0]    load_bits;
    logic [DRAW_W-1:0]    draw_first;
    logic [DRAW_W-1:0]    draw_second;
    logic [DRAW_W-1:0]    draw_third;

    modport source (
        output valid, cmd, cell_x, cell_y, load_bits, draw_first, draw_second, draw_third,
        input  ready
    );
    modport sink (
        input  valid, cmd, cell_x, cell_y, load_bits, draw_first, draw_second, draw_third,
        output ready
    );
endinterface

interface lgrs_out_if import lgrs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BITS_W-1:0]    cell_bits;
    logic [ROT_W-1:0]     rotation;

    modport source (output valid, cell_bits, rotation, input ready);
    modport sink (input valid, cell_bits, rotation, output ready);
endinterface

interface lgrs_cfg_if import lgrs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [THR_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lattice_gas_rotate_and_stream_top.sv =====
// Lattice gas rotate-and-stream block: two banks of cell memories of four bit planes each,
// and a two-step sequencer. Depends on lgrs_pkg and the interfaces in lgrs_channels_if.sv.
//
// Usage.
// Commands arrive on the item channel; each accepted transaction yields exactly one
// transaction on the result channel. Load writes a cell of the current grid, read returns
// a cell of the current grid, collide picks a rotation from the draws and streams the
// rotated bits into the next-step grid at the four neighbours, commit swaps the grids.
// The three thresholds are written on the cfg channel, which is always ready; they should
// only be changed while no command is in progress.
// Timing: a command is accepted at one clock edge; its cell is read from memory at that
// same edge. In the write-back step, once the result register is free, the write-back is
// done and the result register is loaded. Each command runs read then write-back, and
// the block accepts no new command until the write-back of the previous one is done.
// After reset the block sweeps both grids to zero, one cell address per cycle, over all
// 2**(X_W + Y_W) addresses (65536 for a 256 by 256 grid); item.ready stays low meanwhile.
// If the receiver stalls, a finished result waits in the output register and one further
// command may be accepted; that command holds in its write-back step until the result
// register is free, so nothing is lost or written twice.
`default_nettype none

module lattice_gas_rotate_and_stream_top import lgrs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    lgrs_in_if.sink     item,
    lgrs_out_if.source  result,
    lgrs_cfg_if.sink    cfg
);

    // Sequencer and control state.
    state_t                 state_reg;
    state_t                 state_next;
    logic [ADDR_W-1:0]      clear_addr_reg;
    logic [ADDR_W-1:0]      clear_addr_next;
    logic                   bank_reg;
    logic                   bank_next;
    logic [THR_W-1:0]       stay_reg;
    logic [THR_W-1:0]       quarter_reg;
    logic [THR_W-1:0]       half_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    // Captured command payload.
    cmd_t                   cmd_reg;
    logic [X_W-1:0]         x_reg;
    logic [Y_W-1:0]         y_reg;
    logic [BITS_W-1:0]      load_reg;
    logic [DRAW_W-1:0]      draw_first_reg;
    logic [DRAW_W-1:0]      draw_second_reg;
    logic [DRAW_W-1:0]      draw_third_reg;
    logic [BITS_W-1:0]      out_bits_reg;
    logic [ROT_W-1:0]       out_rot_reg;

    // Memory ports: one write port and one read port per bit plane of each bank.
    logic                   we    [2][BITS_W];
    logic [ADDR_W-1:0]      waddr [2][BITS_W];
    logic                   wdata [2][BITS_W];
    logic                   rd_reg [2][BITS_W];
    logic [ADDR_W-1:0]      rd_addr;
    logic                   rd_en;

    logic                   item_fire;
    logic                   exec_fire;
    logic                   clear_done;
    logic [BITS_W-1:0]      cell_now;
    logic [BITS_W-1:0]      cell_rot;
    logic [ROT_W-1:0]       rot;
    logic [X_W-1:0]         x_plus;
    logic [X_W-1:0]         x_minus;
    logic [Y_W-1:0]         y_plus;
    logic [Y_W-1:0]         y_minus;
    logic [ADDR_W-1:0]      cell_addr;
    logic [ADDR_W-1:0]      nbr_addr [BITS_W];

    assign item_fire  = item.valid && item.ready;
    assign exec_fire  = (state_reg == ST_EXEC) && (!out_valid_reg || result.ready);
    assign clear_done = (clear_addr_reg == {ADDR_W{1'b1}});

    // The cell is read at the edge that accepts the command.
    assign rd_en   = item_fire;
    assign rd_addr = {Y_WRAP[item.cell_y], X_WRAP[item.cell_x]};

    // ------------------------------------------------------------------
    // Grid memories. Each bank is split into four one-bit planes so that a
    // collide writes every neighbour's own direction bit in the same cycle,
    // one write per plane, without a read-modify-write of the neighbour.
    // ------------------------------------------------------------------
    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        for (genvar k = 0; k < BITS_W; k++)
        begin : g_plane
            logic mem [CELL_COUNT];

            always_ff @(posedge clk)
            begin
                if (we[b][k])
                begin
                    mem[waddr[b][k]] <= wdata[b][k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rd_en)
                begin
                    rd_reg[b][k] <= mem[rd_addr];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath of the write-back step.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < BITS_W; k++)
        begin
            cell_now[k] = bank_reg ? rd_reg[1][k] : rd_reg[0][k];
        end
    end

    // The first test that hits decides the rotation; a threshold of 65536 always hits.
    always_comb
    begin
        if ({1'b0, draw_first_reg} < stay_reg)
        begin
            rot = ROT_W'(0);
        end
        else if ({1'b0, draw_second_reg} < quarter_reg)
        begin
            rot = ROT_W'(1);
        end
        else if ({1'b0, draw_third_reg} < half_reg)
        begin
            rot = ROT_W'(2);
        end
        else
        begin
            rot = ROT_W'(3);
        end
    end

    // Rotation by r quarter turns moves direction bit k to bit (k + r) mod 4.
    always_comb
    begin
        case (rot)
            ROT_W'(1): cell_rot = {cell_now[2:0], cell_now[3]};
            ROT_W'(2): cell_rot = {cell_now[1:0], cell_now[3:2]};
            ROT_W'(3): cell_rot = {cell_now[0], cell_now[3:1]};
            default:   cell_rot = cell_now;
        endcase
    end

    // Periodic neighbours.
    assign x_plus  = (x_reg == X_W'(GRID_WIDTH - 1))  ? '0 : x_reg + X_W'(1);
    assign x_minus = (x_reg == '0) ? X_W'(GRID_WIDTH - 1)  : x_reg - X_W'(1);
    assign y_plus  = (y_reg == Y_W'(GRID_HEIGHT - 1)) ? '0 : y_reg + Y_W'(1);
    assign y_minus = (y_reg == '0) ? Y_W'(GRID_HEIGHT - 1) : y_reg - Y_W'(1);

    assign cell_addr   = {y_reg, x_reg};
    assign nbr_addr[0] = {y_reg, x_plus};
    assign nbr_addr[1] = {y_plus, x_reg};
    assign nbr_addr[2] = {y_reg, x_minus};
    assign nbr_addr[3] = {y_minus, x_reg};

    // Write-port steering: clearing sweep, load into the current bank, or the
    // collide streaming into the next-step bank.
    always_comb
    begin
        for (int b = 0; b < 2; b++)
        begin
            for (int k = 0; k < BITS_W; k++)
            begin
                we[b][k]    = 1'b0;
                waddr[b][k] = cell_addr;
                wdata[b][k] = load_reg[k];
                if (state_reg == ST_CLEAR)
                begin
                    we[b][k]    = 1'b1;
                    waddr[b][k] = clear_addr_reg;
                    wdata[b][k] = 1'b0;
                end
                else if (exec_fire && (cmd_reg == CMD_LOAD))
                begin
                    we[b][k] = (b[0] == bank_reg);
                end
                else if (exec_fire && (cmd_reg == CMD_COLLIDE))
                begin
                    we[b][k]    = (b[0] != bank_reg);
                    waddr[b][k] = nbr_addr[k];
                    wdata[b][k] = cell_rot[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Sequencer: outputs and control register updates.
    always_comb
    begin
        item.ready      = 1'b0;
        clear_addr_next = clear_addr_reg;
        bank_next       = bank_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                item.ready = 1'b1;
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_reg == CMD_COMMIT)
                    begin
                        bank_next = !bank_reg;
                    end
                end
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    // Configuration is never held off.
    assign cfg.ready = 1'b1;

    assign result.valid     = out_valid_reg;
    assign result.cell_bits = out_bits_reg;
    assign result.rotation  = out_rot_reg;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            bank_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            stay_reg       <= STAY_RESET;
            quarter_reg    <= QUARTER_RESET;
            half_reg       <= HALF_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            bank_reg       <= bank_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_STAY:    stay_reg    <= cfg.data;
                    CFG_QUARTER: quarter_reg <= cfg.data;
                    CFG_HALF:    half_reg    <= cfg.data;
                    default:     ;
                endcase
            end
        end
    end

    // Command payload, captured at acceptance with the coordinates already wrapped.
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            cmd_reg         <= cmd_t'(item.cmd);
            x_reg           <= X_WRAP[item.cell_x];
            y_reg           <= Y_WRAP[item.cell_y];
            load_reg        <= item.load_bits;
            draw_first_reg  <= item.draw_first;
            draw_second_reg <= item.draw_second;
            draw_third_reg  <= item.draw_third;
        end
    end

    // Result payload: read data only for a read, rotation only for a collide.
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_bits_reg <= (cmd_reg == CMD_READ) ? cell_now : '0;
            out_rot_reg  <= (cmd_reg == CMD_COLLIDE) ? rot : '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lgrs_checker.sv =====
// Port-level checker for the lattice gas block, bound to the top level.
// Depends on lgrs_pkg and lattice_gas_rotate_and_stream_top_macros.svh.
`default_nettype none
`include "lattice_gas_rotate_and_stream_top_macros.svh"

module lgrs_checker import lgrs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  logic              result_valid,
    input  logic              result_ready,
    input  logic [BITS_W-1:0] cell_bits,
    input  logic [ROT_W-1:0]  rotation
);

    // Only one command is worked on at a time.
    `LGRS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, item_valid && item_ready, !item_ready, "item accepted while the previous command is in progress")

    // A fresh result follows its command's read and write-back steps directly, with no stall between.
    `LGRS_ASSERT_IMPLY(a_result_latency, clk, rst_n, $rose(result_valid), $past(item_valid && item_ready, 2), "result appeared without a command two cycles earlier")

    // A stalled result stays offered and unchanged.
    `LGRS_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid, "stalled result withdrawn")
    `LGRS_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && !result_ready, $stable(cell_bits) && $stable(rotation), "stalled result changed")

endmodule

bind lattice_gas_rotate_and_stream_top lgrs_checker u_lgrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cell_bits    (result.cell_bits),
    .rotation     (result.rotation)
);

`default_nettype wire
